>>> sv/bmpu_pkg.sv
`default_nettype none

package bmpu_pkg;

    // Widths fixed by the word formats
    localparam int COLOUR_W  = 24;
    localparam int INDEX_W   = 24;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 13;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

    // Pixel mode codes
    localparam logic [2:0] MODE_1BPP  = 3'd0;
    localparam logic [2:0] MODE_4BPP  = 3'd1;
    localparam logic [2:0] MODE_8BPP  = 3'd2;
    localparam logic [2:0] MODE_24BPP = 3'd3;
    localparam logic [2:0] MODE_32BPP = 3'd4;

    // Input word kinds
    localparam logic ACT_PALETTE = 1'b0;
    localparam logic ACT_DATA    = 1'b1;

    localparam logic [7:0] NIBBLE_MASK = 8'h0f;
    localparam int         ROW_ALIGN   = 4;

    typedef logic [COLOUR_W-1:0] colour_t;

endpackage

`default_nettype wire

>>> sv/bmpu_palette_ram.sv
`default_nettype none

module bmpu_palette_ram #(
    parameter int DEPTH = 256
) (
    input  wire logic                       clk,
    input  wire logic                       wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
    input  wire bmpu_pkg::colour_t          wr_data,
    input  wire logic                       rd_en,
    input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
    output bmpu_pkg::colour_t               rd_data
);
    import bmpu_pkg::*;

    colour_t mem [DEPTH];
    colour_t rd_data_reg;

    // Hold the read data while the stage behind it is stalled
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> sv/bmp_pixel_unpacker_top.sv
`default_nettype none

// Channel   Direction  Handshake            Word
// in        sink       in_valid / in_stall  action, data_byte, palette_index, palette_rgb
// out       source     out_valid/out_stall  pixel_index, red, green, blue, alpha, flags
// cfg       sink       cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One pixel leaves per cycle while out_stall is low; a data byte in 8, 24 or 32 bits per
// pixel and every palette word is taken without raising in_stall of its own. A byte in
// 1- or 4-bit mode raises in_stall while it yields its extra pixels (up to seven), as the
// single colour store read port serves one lookup a cycle; pixels pass stages B and C.
// Reset clears counters and pipeline valids; the colour store is not cleared.
// A stall on the output ripples back through the two internal stages to in_stall.

module bmp_pixel_unpacker_top #(
    parameter int MAX_WIDTH     = 4096,
    parameter int MAX_HEIGHT    = 4096,
    parameter int PALETTE_DEPTH = 256
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // input words
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic                              action,
    input  wire logic [7:0]                        data_byte,
    input  wire logic [7:0]                        palette_index,
    input  wire logic [7:0]                        palette_red,
    input  wire logic [7:0]                        palette_green,
    input  wire logic [7:0]                        palette_blue,
    // output pixels
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [bmpu_pkg::INDEX_W-1:0]           pixel_index,
    output logic [7:0]                             red,
    output logic [7:0]                             green,
    output logic [7:0]                             blue,
    output logic [7:0]                             alpha,
    output logic                                   last_of_byte,
    output logic                                   image_end,
    // configuration writes
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [bmpu_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [bmpu_pkg::CFG_DAT_W-1:0]    cfg_data
);
    import bmpu_pkg::*;

    // Counter widths: a column or row number never exceeds the 13-bit size register
    localparam int CW  = ($clog2(MAX_WIDTH) < CFG_DAT_W) ? $clog2(MAX_WIDTH) : CFG_DAT_W;
    localparam int RW  = ($clog2(MAX_HEIGHT) < CFG_DAT_W) ? $clog2(MAX_HEIGHT) : CFG_DAT_W;
    localparam int PW  = RW + CW + 1;
    localparam int IXW = (PW > INDEX_W) ? PW : INDEX_W;
    localparam int AW  = $clog2(PALETTE_DEPTH);

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    logic          cfg_we;
    int            cfg_eff_w;
    int            cfg_eff_h;

    logic [2:0]    mode_reg,   mode_next;
    logic [CW:0]   w_reg,      w_next;
    logic [CW-1:0] w_last_reg, w_last_next;
    logic [RW-1:0] h_last_reg, h_last_next;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && (cfg_index == REG_PIXEL_MODE
                                  || cfg_index == REG_IMAGE_WIDTH
                                  || cfg_index == REG_IMAGE_HEIGHT);

    // Clamp the written size: zero acts as one, above the maximum acts as the maximum
    always_comb
    begin
        if (cfg_data == '0)
        begin
            cfg_eff_w = 1;
            cfg_eff_h = 1;
        end
        else
        begin
            cfg_eff_w = (int'(cfg_data) > MAX_WIDTH)  ? MAX_WIDTH  : int'(cfg_data);
            cfg_eff_h = (int'(cfg_data) > MAX_HEIGHT) ? MAX_HEIGHT : int'(cfg_data);
        end
    end

    always_comb
    begin
        mode_next   = mode_reg;
        w_next      = w_reg;
        w_last_next = w_last_reg;
        h_last_next = h_last_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_PIXEL_MODE:   mode_next = cfg_data[2:0];
                REG_IMAGE_WIDTH:
                begin
                    w_next      = (CW+1)'(cfg_eff_w);
                    w_last_next = CW'(cfg_eff_w - 1);
                end
                REG_IMAGE_HEIGHT: h_last_next = RW'(cfg_eff_h - 1);
                default:          mode_next = mode_reg;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage A: byte decode, pixel expansion and raster counters
    // ------------------------------------------------------------------
    logic          b_ready;

    logic [CW-1:0] col_reg,      col_next;
    logic [RW-1:0] drow_reg,     drow_next;    // destination row, top row is 0
    logic          complete_reg, complete_next;
    logic [1:0]    bip_reg,      bip_next;     // byte within a multi-byte pixel
    logic [1:0]    phase_reg,    phase_next;   // row data bytes mod 4
    logic [1:0]    pad_reg,      pad_next;     // padding bytes still to drop
    colour_t       held_reg,     held_next;
    logic          busy_reg,     busy_next;    // a sub-byte word still has pixels
    logic [2:0]    sub_reg,      sub_next;
    logic [7:0]    byte_reg,     byte_next;

    logic          pal_acc;
    logic          data_acc;
    logic          live;
    logic          emit_new;
    logic          a_fire;
    logic [7:0]    cur_byte;
    logic [2:0]    cur_sub;
    logic [1:0]    phase_cur;
    logic [7:0]    look_idx;
    logic          byte_done;
    logic          row_end;
    logic          a_last;
    logic          a_end;
    logic          a_direct;
    colour_t       a_rgb;
    logic [7:0]    a_alpha;

    assign in_stall = busy_reg || !b_ready;
    assign pal_acc  = in_valid && !in_stall && (action == ACT_PALETTE);
    assign data_acc = in_valid && !in_stall && (action == ACT_DATA);
    assign live     = data_acc && !complete_reg && (mode_reg <= MODE_32BPP) && (pad_reg == '0);

    assign cur_byte  = busy_reg ? byte_reg : data_byte;
    assign cur_sub   = busy_reg ? sub_reg : 3'd0;
    assign phase_cur = live ? (phase_reg + 2'd1) : phase_reg;
    assign a_direct  = (mode_reg == MODE_24BPP) || (mode_reg == MODE_32BPP);

    // Palette index of the pixel in hand; MSB first within the byte
    always_comb
    begin
        case (mode_reg)
            MODE_1BPP: look_idx = {7'd0, cur_byte[3'd7 - cur_sub]};
            MODE_4BPP: look_idx = cur_sub[0] ? (cur_byte & NIBBLE_MASK) : (cur_byte >> 4);
            default:   look_idx = cur_byte;
        endcase
    end

    always_comb
    begin
        case (mode_reg)
            MODE_1BPP: byte_done = (cur_sub == 3'd7);
            MODE_4BPP: byte_done = (cur_sub == 3'd1);
            default:   byte_done = 1'b1;
        endcase
    end

    assign row_end = (col_reg == w_last_reg);
    assign a_last  = row_end || byte_done;
    assign a_end   = row_end && (drow_reg == '0);

    always_comb
    begin
        col_next      = col_reg;
        drow_next     = drow_reg;
        complete_next = complete_reg;
        bip_next      = bip_reg;
        phase_next    = phase_cur;
        pad_next      = pad_reg;
        held_next     = held_reg;
        busy_next     = busy_reg;
        sub_next      = sub_reg;
        byte_next     = byte_reg;
        emit_new      = 1'b0;
        a_rgb         = held_reg;
        a_alpha       = 8'd0;

        // drop one padding byte
        if (data_acc && !complete_reg && (mode_reg <= MODE_32BPP) && (pad_reg != '0))
        begin
            pad_next = pad_reg - 2'd1;
        end

        if (live)
        begin
            case (mode_reg) inside
                MODE_1BPP, MODE_4BPP, MODE_8BPP: emit_new = 1'b1;
                MODE_24BPP:
                begin
                    a_rgb = {data_byte, held_reg[15:0]};
                    if (bip_reg >= 2'd2)
                    begin
                        emit_new = 1'b1;
                    end
                end
                default:
                begin
                    a_alpha = data_byte;
                    if (bip_reg == 2'd3)
                    begin
                        emit_new = 1'b1;
                    end
                end
            endcase
            // accumulate the leading bytes of a wide pixel
            if (a_direct && !emit_new)
            begin
                held_next = held_reg | (colour_t'(data_byte) << (8 * int'(bip_reg)));
                bip_next  = bip_reg + 2'd1;
            end
        end

        a_fire = busy_reg ? b_ready : emit_new;

        if (a_fire)
        begin
            busy_next = !a_last;
            sub_next  = cur_sub + 3'd1;
            byte_next = cur_byte;
            if (a_direct)
            begin
                bip_next  = 2'd0;
                held_next = '0;
            end
            if (row_end)
            begin
                col_next   = '0;
                pad_next   = 2'(ROW_ALIGN - int'(phase_cur));
                phase_next = 2'd0;
                if (drow_reg == '0)
                begin
                    complete_next = 1'b1;
                end
                else
                begin
                    drow_next = drow_reg - RW'(1);
                end
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end

        // register write restarts the image
        if (cfg_we)
        begin
            col_next      = '0;
            drow_next     = h_last_next;
            complete_next = 1'b0;
            bip_next      = 2'd0;
            phase_next    = 2'd0;
            pad_next      = 2'd0;
            held_next     = '0;
            busy_next     = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Colour store
    // ------------------------------------------------------------------
    logic    pal_we;
    colour_t pal_q;

    assign pal_we = pal_acc && (int'(palette_index) < PALETTE_DEPTH);

    bmpu_palette_ram #(
        .DEPTH   (PALETTE_DEPTH)
    ) u_palette (
        .clk     (clk),
        .wr_en   (pal_we),
        .wr_addr (palette_index[AW-1:0]),
        .wr_data ({palette_red, palette_green, palette_blue}),
        .rd_en   (a_fire),
        .rd_addr (look_idx[AW-1:0]),
        .rd_data (pal_q)
    );

    // ------------------------------------------------------------------
    // Stage B: palette read data, row base product
    // ------------------------------------------------------------------
    logic          c_ready;
    logic          b_valid_reg;
    logic          b_direct_reg;
    logic          b_zero_reg;
    colour_t       b_rgb_reg;
    logic [7:0]    b_alpha_reg;
    logic          b_last_reg;
    logic          b_end_reg;
    logic [CW-1:0] b_col_reg;
    logic [PW-1:0] b_prod_reg;
    logic          c_load;
    logic [IXW-1:0] idx_sum;
    colour_t       c_rgb;

    assign b_ready = !b_valid_reg || c_ready;
    assign c_load  = b_valid_reg && c_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg <= a_fire || (b_valid_reg && !c_ready);
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_fire)
        begin
            b_direct_reg <= a_direct;
            b_zero_reg   <= !a_direct && (int'(look_idx) >= PALETTE_DEPTH);
            b_rgb_reg    <= a_rgb;
            b_alpha_reg  <= a_alpha;
            b_last_reg   <= a_last;
            b_end_reg    <= a_end;
            b_col_reg    <= col_reg;
            b_prod_reg   <= PW'(drow_reg) * PW'(w_reg);
        end
    end

    // ------------------------------------------------------------------
    // Stage C: output register
    // ------------------------------------------------------------------
    logic       out_valid_reg;
    logic [INDEX_W-1:0] pixel_index_reg;
    colour_t    rgb_reg;
    logic [7:0] alpha_reg;
    logic       last_reg;
    logic       end_reg;

    assign c_ready = !out_valid_reg || !out_stall;
    assign idx_sum = IXW'(b_prod_reg) + IXW'(b_col_reg);
    assign c_rgb   = b_direct_reg ? b_rgb_reg : (b_zero_reg ? '0 : pal_q);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= c_load || (out_valid_reg && out_stall);
        end
    end

    always_ff @(posedge clk)
    begin
        if (c_load)
        begin
            pixel_index_reg <= idx_sum[INDEX_W-1:0];
            rgb_reg         <= c_rgb;
            alpha_reg       <= b_alpha_reg;
            last_reg        <= b_last_reg;
            end_reg         <= b_end_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign pixel_index  = pixel_index_reg;
    assign red          = rgb_reg[23:16];
    assign green        = rgb_reg[15:8];
    assign blue         = rgb_reg[7:0];
    assign alpha        = alpha_reg;
    assign last_of_byte = last_reg;
    assign image_end    = end_reg;

    // ------------------------------------------------------------------
    // State registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_8BPP;
            w_reg        <= (CW+1)'(1);
            w_last_reg   <= '0;
            h_last_reg   <= '0;
            col_reg      <= '0;
            drow_reg     <= '0;
            complete_reg <= 1'b0;
            bip_reg      <= 2'd0;
            phase_reg    <= 2'd0;
            pad_reg      <= 2'd0;
            held_reg     <= '0;
            busy_reg     <= 1'b0;
            sub_reg      <= 3'd0;
        end
        else
        begin
            mode_reg     <= mode_next;
            w_reg        <= w_next;
            w_last_reg   <= w_last_next;
            h_last_reg   <= h_last_next;
            col_reg      <= col_next;
            drow_reg     <= drow_next;
            complete_reg <= complete_next;
            bip_reg      <= bip_next;
            phase_reg    <= phase_next;
            pad_reg      <= pad_next;
            held_reg     <= held_next;
            busy_reg     <= busy_next;
            sub_reg      <= sub_next;
        end
    end

    // byte held across a multi-pixel expansion
    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

endmodule

`default_nettype wire
